// ===== hdl/euler_path_existence_checker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Euler path checker assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EULER_PATH_EXISTENCE_CHECKER_CORE_DEFINES_SVH
`define EULER_PATH_EXISTENCE_CHECKER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("euler path checker: property violated");

// Consequent must hold in the cycle after the antecedent.
`define EPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("euler path checker: property violated");

`endif

// ===== hdl/epc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler path checker package
// Shared types and fixed field widths of the Euler path checker.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int NODE_FIELD_W = 5;
  localparam int S_TDATA_W    = 16;
  localparam int M_TDATA_W    = 8;

  typedef enum logic {
    CMD_ADD_EDGE = 1'b0,
    CMD_EVALUATE = 1'b1
  } epc_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUT_UPD,
    S_IN_UPD,
    S_FIND_U,
    S_FIND_V,
    S_EVAL,
    S_DONE
  } epc_state_e;

  // Scan control from the sequencer to the evaluation accumulator.
  typedef struct packed {
    logic clear;
    logic check;
    logic used;
  } epc_scan_ctl_t;

  typedef struct packed {
    logic connected;
    logic balanced;
  } epc_verdict_t;

endpackage

// ===== hdl/epc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler path checker node RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module epc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/epc_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler path checker evaluation accumulator
// Classifies one scanned node per cycle and keeps the running verdict.
// ----------------------------------------------------------------------------
module epc_eval #(
  parameter int NODE_W       = 5,
  parameter int DEGREE_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  epc_pkg::epc_scan_ctl_t    ctl_i,
  input  logic [NODE_W-1:0]         idx_i,
  input  logic [NODE_W-1:0]         parent_i,
  input  logic [DEGREE_WIDTH-1:0]   in_deg_i,
  input  logic [DEGREE_WIDTH-1:0]   out_deg_i,
  output epc_pkg::epc_verdict_t     verdict_o
);

  localparam logic [1:0] CNT_MANY = 2'd2;

  logic [1:0] roots_q, ext_in_q, ext_out_q;
  logic       bad_q;
  logic       is_root, deg_eq, in_plus, out_plus;

  assign is_root  = ctl_i.used && (parent_i == idx_i);
  assign deg_eq   = in_deg_i == out_deg_i;
  assign in_plus  = {1'b0, in_deg_i} == ({1'b0, out_deg_i} + 1'b1);
  assign out_plus = {1'b0, out_deg_i} == ({1'b0, in_deg_i} + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roots_q   <= '0;
      ext_in_q  <= '0;
      ext_out_q <= '0;
      bad_q     <= 1'b0;
    end else if (ctl_i.clear) begin
      roots_q   <= '0;
      ext_in_q  <= '0;
      ext_out_q <= '0;
      bad_q     <= 1'b0;
    end else if (ctl_i.check && ctl_i.used) begin
      // Saturate counts at two: only zero, one or more matter.
      if (is_root && roots_q != CNT_MANY) roots_q <= roots_q + 2'd1;
      if (!deg_eq) begin
        if (in_plus) begin
          if (ext_in_q != CNT_MANY) ext_in_q <= ext_in_q + 2'd1;
        end else if (out_plus) begin
          if (ext_out_q != CNT_MANY) ext_out_q <= ext_out_q + 2'd1;
        end else begin
          bad_q <= 1'b1;
        end
      end
    end
  end

  assign verdict_o.connected = roots_q != CNT_MANY;
  assign verdict_o.balanced  = !bad_q &&
                               ((ext_in_q == 2'd0 && ext_out_q == 2'd0) ||
                                (ext_in_q == 2'd1 && ext_out_q == 2'd1));

endmodule

// ===== hdl/euler_path_existence_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler path existence checker core
// Loads directed edges, tracks degrees and union-find sets in RAM, and
// answers whether a directed Euler path exists on an evaluate command.
// ----------------------------------------------------------------------------
// The core takes one transaction at a time on the slave stream. tuser is the
// command (0 adds the edge start_node -> end_node, 1 evaluates and clears).
// An added edge does one read-modify-write each for the out-degree and
// in-degree entry in the degree RAM, then walks the parent links of both
// endpoints to their roots in the parent RAM, one step per read; that RAM
// has one read per cycle. An edge with an endpoint at NODE_COUNT or above
// is dropped. An evaluate scans both RAMs one node a cycle, then places the
// result in the output register and clears all state at once; it waits
// there only while an earlier result is still untaken. Edges are accepted
// while a result waits.
// Node-used flags live in flip-flops and act as valid bits for both RAMs, so
// no clearing pass is needed after reset or after evaluate.
// Degree counters saturate at all ones and flag an overflow, which forces
// the answer to not possible.
// ----------------------------------------------------------------------------
module euler_path_existence_checker_core #(
  parameter int NODE_COUNT   = 26,
  parameter int DEGREE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] start_node, [9:5] end_node, [15:10] zero
  input  logic [epc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] possible, [1] count_overflow, [7:2] zero
  output logic [epc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int IDX_W  = $clog2(NODE_COUNT + 1);
  localparam int CMP_W  = (IDX_W > epc_pkg::NODE_FIELD_W) ? IDX_W : epc_pkg::NODE_FIELD_W;
  localparam int ENT_W  = 2 * DEGREE_WIDTH;
  localparam logic [DEGREE_WIDTH-1:0] DEG_MAX = {DEGREE_WIDTH{1'b1}};
  localparam int FW = epc_pkg::NODE_FIELD_W;

  epc_pkg::epc_state_e state_q, state_d;

  // Input decode
  logic              s_accept, is_eval, edge_ok;
  logic [NODE_W-1:0] u_addr, v_addr;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign is_eval  = s_axis_tuser == epc_pkg::CMD_EVALUATE;
  assign u_addr   = NODE_W'(s_axis_tdata[FW-1:0]);
  assign v_addr   = NODE_W'(s_axis_tdata[2*FW-1:FW]);
  assign edge_ok  = (CMP_W'(s_axis_tdata[FW-1:0]) < CMP_W'(NODE_COUNT)) &&
                    (CMP_W'(s_axis_tdata[2*FW-1:FW]) < CMP_W'(NODE_COUNT));

  // Edge registers
  logic [NODE_W-1:0]  u_q, v_q, cur_q, ru_q;
  logic               rd_vld_q, fwd_q;
  logic [ENT_W-1:0]   wd_q;
  logic [NODE_COUNT-1:0] used_q;
  logic               sat_q;

  // Evaluation scan registers
  logic [IDX_W-1:0]   idx_q;
  logic               chk_en_q, chk_used_q;
  logic [NODE_W-1:0]  chk_idx_q;
  logic               idx_live;

  logic               m_valid_q;
  logic [1:0]         m_data_q;

  // RAM ports
  logic               deg_we, par_we;
  logic [NODE_W-1:0]  deg_waddr, deg_raddr, par_waddr, par_raddr, par_wdata;
  logic [ENT_W-1:0]   deg_wdata, deg_rdata;
  logic [NODE_W-1:0]  par_rdata;

  // Degree entry after masking and forwarding
  logic [ENT_W-1:0]        ent;
  logic [DEGREE_WIDTH-1:0] ent_in, ent_out, in_new, out_new;
  logic                    in_full, out_full, hit;
  logic                    sat_set, out_load;

  epc_pkg::epc_scan_ctl_t  scan_ctl;
  epc_pkg::epc_verdict_t   verdict;

  // An entry of a node not yet used reads as zero degrees; a self loop
  // reads back the out-degree update written the cycle before.
  assign ent      = (state_q == epc_pkg::S_IN_UPD && fwd_q) ? wd_q :
                    (rd_vld_q ? deg_rdata : '0);
  assign ent_in   = ent[ENT_W-1:DEGREE_WIDTH];
  assign ent_out  = ent[DEGREE_WIDTH-1:0];
  assign in_full  = ent_in == DEG_MAX;
  assign out_full = ent_out == DEG_MAX;
  assign in_new   = in_full ? ent_in : ent_in + 1'b1;
  assign out_new  = out_full ? ent_out : ent_out + 1'b1;
  assign hit      = par_rdata == cur_q;
  assign idx_live = idx_q < IDX_W'(NODE_COUNT);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      epc_pkg::S_IDLE: begin
        if (s_accept) begin
          if (is_eval)      state_d = epc_pkg::S_EVAL;
          else if (edge_ok) state_d = epc_pkg::S_OUT_UPD;
        end
      end
      epc_pkg::S_OUT_UPD: state_d = epc_pkg::S_IN_UPD;
      epc_pkg::S_IN_UPD:  state_d = epc_pkg::S_FIND_U;
      epc_pkg::S_FIND_U:  if (hit) state_d = epc_pkg::S_FIND_V;
      epc_pkg::S_FIND_V:  if (hit) state_d = epc_pkg::S_IDLE;
      epc_pkg::S_EVAL:    if (!idx_live) state_d = epc_pkg::S_DONE;
      epc_pkg::S_DONE:    if (!m_valid_q || m_axis_tready) state_d = epc_pkg::S_IDLE;
      default:            state_d = epc_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: RAM controls, scan control, handshake
  always_comb begin
    s_axis_tready  = 1'b0;
    deg_we         = 1'b0;
    deg_waddr      = u_q;
    deg_wdata      = {ent_in, out_new};
    deg_raddr      = u_addr;
    par_we         = 1'b0;
    par_waddr      = u_q;
    par_wdata      = u_q;
    par_raddr      = u_q;
    sat_set        = 1'b0;
    out_load       = 1'b0;
    scan_ctl.clear = 1'b0;
    scan_ctl.check = 1'b0;
    scan_ctl.used  = chk_used_q;
    unique case (state_q)
      epc_pkg::S_IDLE: begin
        s_axis_tready  = 1'b1;
        scan_ctl.clear = s_accept && is_eval;
      end
      epc_pkg::S_OUT_UPD: begin
        // Bump out-degree of the source; seed its parent link on first use.
        deg_we    = 1'b1;
        deg_waddr = u_q;
        deg_wdata = {ent_in, out_new};
        par_we    = !used_q[u_q];
        par_waddr = u_q;
        par_wdata = u_q;
        deg_raddr = v_q;
        sat_set   = out_full;
      end
      epc_pkg::S_IN_UPD: begin
        deg_we    = 1'b1;
        deg_waddr = v_q;
        deg_wdata = {in_new, ent_out};
        par_we    = !used_q[v_q];
        par_waddr = v_q;
        par_wdata = v_q;
        par_raddr = u_q;
        sat_set   = in_full;
      end
      epc_pkg::S_FIND_U: begin
        par_raddr = hit ? v_q : par_rdata;
      end
      epc_pkg::S_FIND_V: begin
        par_raddr = par_rdata;
        // Hang the destination's root under the source's root.
        if (hit && cur_q != ru_q) begin
          par_we    = 1'b1;
          par_waddr = cur_q;
          par_wdata = ru_q;
        end
      end
      epc_pkg::S_EVAL: begin
        deg_raddr      = idx_q[NODE_W-1:0];
        par_raddr      = idx_q[NODE_W-1:0];
        scan_ctl.check = chk_en_q;
      end
      epc_pkg::S_DONE: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= epc_pkg::S_IDLE;
      used_q    <= '0;
      sat_q     <= 1'b0;
      idx_q     <= '0;
      chk_en_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == epc_pkg::S_OUT_UPD) used_q[u_q] <= 1'b1;
      if (state_q == epc_pkg::S_IN_UPD)  used_q[v_q] <= 1'b1;
      if (sat_set) sat_q <= 1'b1;
      if (scan_ctl.clear) begin
        idx_q    <= '0;
        chk_en_q <= 1'b0;
      end else if (state_q == epc_pkg::S_EVAL) begin
        chk_en_q <= idx_live;
        if (idx_live) idx_q <= idx_q + 1'b1;
      end
      // Hold the result until taken; clear the loaded set with it.
      if (out_load) begin
        m_valid_q <= 1'b1;
        used_q    <= '0;
        sat_q     <= 1'b0;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      epc_pkg::S_IDLE: begin
        u_q      <= u_addr;
        v_q      <= v_addr;
        rd_vld_q <= used_q[u_addr];
      end
      epc_pkg::S_OUT_UPD: begin
        rd_vld_q <= used_q[v_q];
        fwd_q    <= u_q == v_q;
        wd_q     <= deg_wdata;
      end
      epc_pkg::S_IN_UPD: begin
        cur_q <= u_q;
      end
      epc_pkg::S_FIND_U: begin
        if (hit) begin
          ru_q  <= cur_q;
          cur_q <= v_q;
        end else begin
          cur_q <= par_rdata;
        end
      end
      epc_pkg::S_FIND_V: begin
        cur_q <= par_rdata;
      end
      epc_pkg::S_EVAL: begin
        chk_idx_q  <= idx_q[NODE_W-1:0];
        chk_used_q <= idx_live && used_q[idx_q[NODE_W-1:0]];
      end
      epc_pkg::S_DONE: begin
        if (out_load) m_data_q <= {sat_q, verdict.connected && verdict.balanced && !sat_q};
      end
      default: ;
    endcase
  end

  epc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  epc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  epc_eval #(
    .NODE_W       (NODE_W),
    .DEGREE_WIDTH (DEGREE_WIDTH)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .idx_i     (chk_idx_q),
    .parent_i  (par_rdata),
    .in_deg_i  (deg_rdata[ENT_W-1:DEGREE_WIDTH]),
    .out_deg_i (deg_rdata[DEGREE_WIDTH-1:0]),
    .verdict_o (verdict)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(epc_pkg::M_TDATA_W - 2){1'b0}}, m_data_q};

endmodule

// ===== hdl/epc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler path checker port checker
// Watches the stream ports of the core over time.
// ----------------------------------------------------------------------------
`include "euler_path_existence_checker_core_defines.svh"

module epc_checker #(
  parameter int NODE_COUNT = 26
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [epc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [epc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic s_accept, m_stall, edge_in_range, out_clean;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_stall       = m_axis_tvalid && !m_axis_tready;
  assign edge_in_range = (int'(s_axis_tdata[4:0]) < NODE_COUNT) &&
                         (int'(s_axis_tdata[9:5]) < NODE_COUNT);
  assign out_clean     = !(m_axis_tdata[0] && m_axis_tdata[1]) &&
                         (m_axis_tdata[7:2] == 6'd0);

  // Hold a stalled result.
  `EPC_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // Overflow always forces not possible; padding stays zero.
  `EPC_ASSERT_NOW(a_ovf_blocks, m_axis_tvalid, out_clean)

  // An evaluate transaction busies the core for the scan.
  `EPC_ASSERT_NEXT(a_eval_busy, s_accept && s_axis_tuser, !s_axis_tready)

  // A valid edge busies the core for its update and root walks.
  `EPC_ASSERT_NEXT(a_edge_busy, s_accept && !s_axis_tuser && edge_in_range, !s_axis_tready)

endmodule

bind euler_path_existence_checker_core epc_checker #(
  .NODE_COUNT (NODE_COUNT)
) u_epc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
